// ----- sv/hcbp_pkg.sv -----
// Shared types and codes for the Huffman code bit packer.
package hcbp_pkg;

	localparam int CODE_W      = 32;
	localparam int LEN_W       = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_ENCODE = 2'd1;
	localparam logic [1:0] OP_FLUSH  = 2'd2;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_FINAL = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [7:0]        symbol;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_length;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] pad_bits;
		logic [1:0] kind;
		logic       last;
	} out_beat_t;

	typedef enum logic [1:0] {
		JOB_ENCODE,
		JOB_FLUSH,
		JOB_ERROR
	} job_op_t;

	typedef struct packed {
		job_op_t           op;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  length;
	} job_t;

endpackage

// ----- sv/hcbp_front.sv -----
// Front end: input stage, code table with valid bits, job classification.
module hcbp_front #(
	parameter int SYMBOL_COUNT = 256,
	parameter int MAX_CODE_LEN = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  hcbp_pkg::in_beat_t in_beat,
	output logic             job_push,
	output hcbp_pkg::job_t   job,
	input  logic             job_full
);
	import hcbp_pkg::*;

	localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  length;
	} entry_t;

	entry_t                  table_mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] tab_valid_q;

	logic             accept;
	logic             sym_in_range;
	logic             len_ok;
	logic             do_load;
	logic [IDX_W-1:0] idx;
	entry_t           wr_entry;

	logic       s1_valid_q;
	logic [1:0] op_s1;
	logic       sym_ok_s1;
	logic       hit_s1;
	entry_t     rd_entry_s1;

	assign accept       = in_valid && !in_stall;
	assign in_stall     = s1_valid_q && job_full;
	assign idx          = in_beat.symbol[IDX_W-1:0];
	assign sym_in_range = {1'b0, in_beat.symbol} < 9'(SYMBOL_COUNT);
	assign len_ok       = 7'(in_beat.code_length) <= 7'(MAX_CODE_LEN);
	assign do_load      = accept && (in_beat.opcode == OP_LOAD) && sym_in_range && len_ok;

	// drop code bits above the length
	always_comb begin
		wr_entry.length = in_beat.code_length;
		for (int i = 0; i < CODE_W; i++) begin
			wr_entry.code[i] = in_beat.code_bits[i] && (7'(i) < 7'(in_beat.code_length));
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			table_mem[idx] <= wr_entry;
		end
		if (accept) begin
			rd_entry_s1 <= table_mem[idx];
			op_s1       <= in_beat.opcode;
			sym_ok_s1   <= sym_in_range;
			hit_s1      <= tab_valid_q[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_valid_q <= '0;
			s1_valid_q  <= 1'b0;
		end else begin
			if (do_load) begin
				tab_valid_q[idx] <= 1'b1;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (!job_full) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// loads and the unused opcode leave the stage without a job
	assign job_push = s1_valid_q && !job_full && ((op_s1 == OP_ENCODE) || (op_s1 == OP_FLUSH));

	always_comb begin
		job.code   = rd_entry_s1.code;
		job.length = rd_entry_s1.length;
		priority if (op_s1 == OP_FLUSH) begin
			job.op = JOB_FLUSH;
		end else if (!sym_ok_s1 || !hit_s1 || (rd_entry_s1.length == '0)) begin
			job.op = JOB_ERROR;
		end else begin
			job.op = JOB_ENCODE;
		end
	end

endmodule

// ----- sv/hcbp_queue.sv -----
// Short job queue between the front end and the packer.
module hcbp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hcbp_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output hcbp_pkg::job_t head_job,
	output logic           nonempty
);
	import hcbp_pkg::*;

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full     = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign nonempty = count_q != '0;
	assign head_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/hcbp_back.sv -----
// Back end: bit accumulator, byte emission and output register.
module hcbp_back #(
	parameter int MAX_CODE_LEN = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  hcbp_pkg::job_t      job,
	output logic                job_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output hcbp_pkg::out_beat_t out_beat
);
	import hcbp_pkg::*;

	localparam int ACC_W = MAX_CODE_LEN + 7;
	localparam int TOT_W = $clog2(ACC_W + 1);

	logic [ACC_W-1:0] acc_q;
	logic [TOT_W-1:0] total_q;
	logic             out_valid_q;
	out_beat_t        out_beat_q;

	logic             out_free;
	logic             has_byte;
	logic             emit;
	logic [TOT_W-1:0] base_total;
	logic             pop_encode;
	logic             pop_single;
	logic [7:0]       byte_val;
	logic [2:0]       cnt;
	logic [2:0]       pad;
	out_beat_t        nxt_beat;

	assign out_free   = !out_valid_q || !out_stall;
	assign has_byte   = total_q >= TOT_W'(8);
	assign emit       = has_byte && out_free;
	assign base_total = emit ? (total_q - TOT_W'(8)) : total_q;

	// an encode may enter in the cycle that drains the last full byte
	assign pop_encode = job_valid && (job.op == JOB_ENCODE) && (base_total < TOT_W'(8));
	assign pop_single = job_valid && ((job.op == JOB_FLUSH) || (job.op == JOB_ERROR))
		&& !has_byte && out_free;
	assign job_pop    = pop_encode || pop_single;

	assign byte_val = 8'(acc_q >> (total_q - TOT_W'(8)));
	assign cnt      = total_q[2:0];
	assign pad      = 3'(4'd8 - {1'b0, cnt});

	always_comb begin
		nxt_beat = '0;
		priority if (emit) begin
			nxt_beat.out_byte = byte_val;
			nxt_beat.kind     = KIND_BYTE;
			nxt_beat.last     = base_total < TOT_W'(8);
		end else if (job.op == JOB_FLUSH) begin
			nxt_beat.last = 1'b1;
			if (cnt != 3'd0) begin
				nxt_beat.out_byte = 8'({1'b0, acc_q[6:0]} << pad);
				nxt_beat.pad_bits = pad;
				nxt_beat.kind     = KIND_FINAL;
			end else begin
				nxt_beat.kind = KIND_DONE;
			end
		end else begin
			nxt_beat.kind = KIND_ERROR;
			nxt_beat.last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_encode) begin
			acc_q <= (acc_q << job.length) | ACC_W'(job.code);
		end
		if (emit || pop_single) begin
			out_beat_q <= nxt_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_encode) begin
				total_q <= base_total + TOT_W'(job.length);
			end else if (pop_single && (job.op == JOB_FLUSH)) begin
				total_q <= '0;
			end else begin
				total_q <= base_total;
			end
			if (emit || pop_single) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

endmodule

// ----- sv/huffman_code_bit_packer_core.sv -----
// Top level of the Huffman code bit packer: front end, job queue, packer.
//
//  channel | direction | handshake           | beat type
//  --------+-----------+---------------------+---------------------
//  in      | input     | in_valid / in_stall | hcbp_pkg::in_beat_t
//  out     | output    | out_valid/out_stall | hcbp_pkg::out_beat_t
//
// Flow: the front end takes one beat per cycle while the job queue is not
// full; a table load writes its entry into the 256-entry table. The packer
// drains one byte per cycle while the output is not stalled; an encode yields
// up to 4 bytes at a 32-bit code, and a flush or an error waits until every
// full byte of an earlier encode has been emitted.
// Reset clears the table valid bits, the pending bit count and all
// handshake state at once; no clearing pass is needed.
// A stall on the output holds the output register and then the packer;
// the four-entry job queue then fills and only then stalls the input.
module huffman_code_bit_packer_core #(
	parameter int SYMBOL_COUNT = 256,
	parameter int MAX_CODE_LEN = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  hcbp_pkg::in_beat_t  in_beat,
	output logic                out_valid,
	input  logic                out_stall,
	output hcbp_pkg::out_beat_t out_beat
);
	import hcbp_pkg::*;

	// jobs from the front end into the queue
	logic job_push;
	job_t push_job;
	logic job_full;

	// jobs from the queue into the packer
	logic job_pop;
	job_t head_job;
	logic job_valid;

	// Classify each beat: loads finish here, encodes carry their table entry.
	hcbp_front #(
		.SYMBOL_COUNT(SYMBOL_COUNT),
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_beat  (in_beat),
		.job_push (job_push),
		.job      (push_job),
		.job_full (job_full)
	);

	// Decouple the input side from multi-byte emission.
	hcbp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.full     (job_full),
		.pop      (job_pop),
		.head_job (head_job),
		.nonempty (job_valid)
	);

	// Append code bits and emit bytes, one result per cycle while the output is not stalled.
	hcbp_back #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (head_job),
		.job_pop   (job_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

endmodule

// ----- sv/hcbp_checker.sv -----
// Port-level checks of the Huffman code bit packer, bound to the top level.
module hcbp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input hcbp_pkg::in_beat_t  in_beat,
	input logic                out_valid,
	input logic                out_stall,
	input hcbp_pkg::out_beat_t out_beat
);
	import hcbp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_beat))
		else $error("stalled output beat changed");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_beat.kind != KIND_BYTE) |-> out_beat.last)
		else $error("flush or error result not marked last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((out_beat.kind == KIND_DONE) || (out_beat.kind == KIND_ERROR))
		|-> (out_beat.out_byte == 8'd0) && (out_beat.pad_bits == 3'd0))
		else $error("done or error result carries data");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_beat.kind == KIND_FINAL)
			? ((out_beat.pad_bits != 3'd0) && !out_beat.out_byte[0])
			: (out_beat.pad_bits == 3'd0)))
		else $error("pad count inconsistent with result kind");

endmodule

bind huffman_code_bit_packer_core hcbp_checker u_hcbp_checker (.*);
